@@ hw/rtl/lif_neuron_layer_core_assert.svh @@
// Assertion macros shared by the LIF neuron layer RTL.
`ifndef LIF_NEURON_LAYER_CORE_ASSERT_SVH
`define LIF_NEURON_LAYER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Check an implication on every rising clock edge outside reset.
`define LIF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
// Check an implication whose consequent is checked in the following cycle, outside reset.
`define LIF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LIF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LIF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/lifnl_pkg.sv @@
// Shared constants, types and helper functions of the LIF neuron layer.
`timescale 1ns / 1ps
package lifnl_pkg;

  // Sizes of the neuron state store (NEURONS is a power of two)
  localparam int NEURONS    = 256;
  localparam int IDX_BITS   = $clog2(NEURONS);
  localparam int NIDX_BITS  = 8;
  localparam int VALUE_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int DECAY_BITS = 16;
  localparam int PROD_BITS  = VALUE_BITS + DECAY_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  // Pipeline stages that hold an item before its state is written back
  localparam int STAGES = 3;
  localparam int STG_A  = 0;
  localparam int STG_B  = 1;
  localparam int STG_C  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SYN_DECAY  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEM_DECAY  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRE_THRES = 2'd2;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [DECAY_BITS-1:0] decay_t;
  typedef logic [IDX_BITS-1:0]   addr_t;
  typedef logic [NIDX_BITS-1:0]  nidx_t;

  localparam value_t VALUE_MAX = '1;
  localparam value_t VALUE_ONE = value_t'(1) << FRAC_BITS;

  localparam decay_t SYN_DECAY_RST  = 16'd52429;
  localparam decay_t MEM_DECAY_RST  = 16'd58982;
  localparam value_t FIRE_THRES_RST = 24'd65536;

  // Per-neuron state word
  typedef struct packed {
    value_t cur;
    value_t mem;
  } state_t;

  // State write-back request
  typedef struct packed {
    logic   en;
    addr_t  addr;
    state_t data;
  } state_wr_t;

  // Occupancy of the stages ahead of write-back
  typedef struct packed {
    logic [STAGES-1:0]             valid;
    logic [STAGES-1:0][IDX_BITS-1:0] addr;
  } busy_t;

  // Add two values, saturating at the maximum
  function automatic value_t sat_add(value_t a, value_t b);
    logic [VALUE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VALUE_BITS] ? VALUE_MAX : s[VALUE_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/lifnl_datapath.sv @@
// Four-stage decay, integrate and fire pipeline of the LIF neuron layer.
`timescale 1ns / 1ps
`include "lif_neuron_layer_core_assert.svh"
module lifnl_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Accepted request and its state read, aligned with stage A
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lifnl_pkg::nidx_t    in_idx_i,
  input  logic                in_spike_i,
  input  logic                in_first_i,
  input  lifnl_pkg::state_t   rd_state_i,
  // Configuration
  input  lifnl_pkg::decay_t   syn_decay_i,
  input  lifnl_pkg::decay_t   mem_decay_i,
  input  lifnl_pkg::value_t   fire_thres_i,
  // Result
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lifnl_pkg::nidx_t    out_idx_o,
  output logic                out_spike_o,
  output lifnl_pkg::value_t   out_level_o,
  // State write-back and stage occupancy
  output lifnl_pkg::state_wr_t wr_o,
  output lifnl_pkg::busy_t     busy_o
);

  // Stage registers
  logic              a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  lifnl_pkg::nidx_t  a_idx_q, b_idx_q, c_idx_q, d_idx_q;
  logic              a_spike_q, a_first_q, b_spike_q;
  lifnl_pkg::value_t b_pc_q, b_pm_q, c_pm_q, c_cur_q;
  logic              d_spike_q;
  lifnl_pkg::value_t d_level_q;

  logic a_ready, b_ready, c_ready, d_ready;

  logic [lifnl_pkg::PROD_BITS-1:0] a_pc, a_pm;
  lifnl_pkg::value_t a_old_cur, a_old_mem;
  lifnl_pkg::value_t b_cur;
  lifnl_pkg::value_t c_sum, c_mem;
  logic              c_fire;

  // Backpressure chain from the output register
  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Stage A: drop old state on a first step, decay both values
  assign a_old_cur = a_first_q ? '0 : rd_state_i.cur;
  assign a_old_mem = a_first_q ? '0 : rd_state_i.mem;
  assign a_pc = {{lifnl_pkg::DECAY_BITS{1'b0}}, a_old_cur}
              * {{lifnl_pkg::VALUE_BITS{1'b0}}, syn_decay_i};
  assign a_pm = {{lifnl_pkg::DECAY_BITS{1'b0}}, a_old_mem}
              * {{lifnl_pkg::VALUE_BITS{1'b0}}, mem_decay_i};

  // Stage B: integrate the input spike into the current
  assign b_cur = lifnl_pkg::sat_add(b_pc_q, b_spike_q ? lifnl_pkg::VALUE_ONE : '0);

  // Stage C: integrate current into the membrane, fire and clear
  assign c_sum  = lifnl_pkg::sat_add(c_pm_q, c_cur_q);
  assign c_fire = (c_sum >= fire_thres_i);
  assign c_mem  = c_fire ? '0 : c_sum;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
      if (d_ready) d_valid_q <= c_valid_q;
    end
  end

  // Payload, advanced with the stage it belongs to
  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_idx_q   <= in_idx_i;
      a_spike_q <= in_spike_i;
      a_first_q <= in_first_i;
    end
    if (b_ready && a_valid_q) begin
      b_idx_q   <= a_idx_q;
      b_spike_q <= a_spike_q;
      b_pc_q    <= a_pc[lifnl_pkg::PROD_BITS-1:lifnl_pkg::FRAC_BITS];
      b_pm_q    <= a_pm[lifnl_pkg::PROD_BITS-1:lifnl_pkg::FRAC_BITS];
    end
    if (c_ready && b_valid_q) begin
      c_idx_q <= b_idx_q;
      c_pm_q  <= b_pm_q;
      c_cur_q <= b_cur;
    end
    if (d_ready && c_valid_q) begin
      d_idx_q   <= c_idx_q;
      d_spike_q <= c_fire;
      d_level_q <= c_mem;
    end
  end

  // Write back as the item leaves stage C
  assign wr_o.en       = c_valid_q && d_ready;
  assign wr_o.addr     = c_idx_q[lifnl_pkg::IDX_BITS-1:0];
  assign wr_o.data.cur = c_cur_q;
  assign wr_o.data.mem = c_mem;

  // Report stages whose state is not yet written
  always_comb begin
    busy_o = '0;
    busy_o.valid[lifnl_pkg::STG_A] = a_valid_q;
    busy_o.valid[lifnl_pkg::STG_B] = b_valid_q;
    busy_o.valid[lifnl_pkg::STG_C] = c_valid_q;
    busy_o.addr[lifnl_pkg::STG_A]  = a_idx_q[lifnl_pkg::IDX_BITS-1:0];
    busy_o.addr[lifnl_pkg::STG_B]  = b_idx_q[lifnl_pkg::IDX_BITS-1:0];
    busy_o.addr[lifnl_pkg::STG_C]  = c_idx_q[lifnl_pkg::IDX_BITS-1:0];
  end

  assign out_valid_o = d_valid_q;
  assign out_idx_o   = d_idx_q;
  assign out_spike_o = d_spike_q;
  assign out_level_o = d_level_q;

  `LIF_ASSERT_IMPL(a_fire_clears, clk_i, rst_ni, d_valid_q && d_spike_q, d_level_q == '0,
                   "fired neuron reports nonzero membrane")
  `LIF_ASSERT_IMPL(a_out_from_c, clk_i, rst_ni, $rose(d_valid_q), $past(c_valid_q),
                   "result appeared without an item in stage C")
  `LIF_ASSERT_NEXT(a_wr_to_out, clk_i, rst_ni, wr_o.en, d_valid_q,
                   "written-back item did not reach the output register")

endmodule

@@ hw/rtl/lif_neuron_layer_core.sv @@
// Top level of the LIF neuron layer: stream ports, config, state store, hazard check.
// A result becomes valid once its request has passed stages A, B, C and the out register.
// Throughput: one request per cycle while the result side is ready and no hazard holds the
// input. A request without first_step for a neuron that still sits in stages A to C waits
// for that neuron's write-back, which a stall on the result side can delay further.
// Reset (rst_ni, async, active low) clears the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`include "lif_neuron_layer_core_assert.svh"
module lif_neuron_layer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [lifnl_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [lifnl_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  // Spike sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] neuron_index, [8] spike_in, [15:9] zero
  input  logic        s_axis_tuser,   // [0] first_step
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [7:0] neuron_out, [8] spike_out,
                                      // [32:9] membrane_level, [39:33] zero
);

  lifnl_pkg::decay_t   syn_decay_q, mem_decay_q;
  lifnl_pkg::value_t   fire_thres_q;
  lifnl_pkg::state_t   state_mem [lifnl_pkg::NEURONS];
  lifnl_pkg::state_t   rd_q;
  lifnl_pkg::state_wr_t wr;
  lifnl_pkg::busy_t    busy;
  lifnl_pkg::addr_t    in_addr;
  lifnl_pkg::nidx_t    out_idx;
  lifnl_pkg::value_t   out_level;
  logic                out_spike;
  logic                dp_ready;
  logic                hazard;
  logic                accept;
  logic                cfg_write;

  assign in_addr = s_axis_tdata[lifnl_pkg::IDX_BITS-1:0];

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syn_decay_q  <= lifnl_pkg::SYN_DECAY_RST;
      mem_decay_q  <= lifnl_pkg::MEM_DECAY_RST;
      fire_thres_q <= lifnl_pkg::FIRE_THRES_RST;
    end else if (cfg_write) begin
      case (cfg_index_i)
        lifnl_pkg::REG_SYN_DECAY:  syn_decay_q  <= cfg_data_i[lifnl_pkg::DECAY_BITS-1:0];
        lifnl_pkg::REG_MEM_DECAY:  mem_decay_q  <= cfg_data_i[lifnl_pkg::DECAY_BITS-1:0];
        lifnl_pkg::REG_FIRE_THRES: fire_thres_q <= cfg_data_i[lifnl_pkg::VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Hold a request without first_step whose neuron still has a state update in flight
  always_comb begin
    hazard = 1'b0;
    for (int s = 0; s < lifnl_pkg::STAGES; s++) begin
      if (busy.valid[s] && (busy.addr[s] == in_addr)) hazard = 1'b1;
    end
    hazard = hazard && !s_axis_tuser;
  end

  assign s_axis_tready = dp_ready && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Neuron state memory: read on accept, write back from stage C
  always_ff @(posedge clk_i) begin
    if (accept) rd_q <= state_mem[in_addr];
    if (wr.en)  state_mem[wr.addr] <= wr.data;
  end

  lifnl_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (accept),
    .in_ready_o   (dp_ready),
    .in_idx_i     (s_axis_tdata[lifnl_pkg::NIDX_BITS-1:0]),
    .in_spike_i   (s_axis_tdata[lifnl_pkg::NIDX_BITS]),
    .in_first_i   (s_axis_tuser),
    .rd_state_i   (rd_q),
    .syn_decay_i  (syn_decay_q),
    .mem_decay_i  (mem_decay_q),
    .fire_thres_i (fire_thres_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_idx_o    (out_idx),
    .out_spike_o  (out_spike),
    .out_level_o  (out_level),
    .wr_o         (wr),
    .busy_o       (busy)
  );

  assign m_axis_tdata = {7'd0, out_level, out_spike, out_idx};

  `LIF_ASSERT_IMPL(a_no_raw_clash, clk_i, rst_ni, accept && wr.en && !s_axis_tuser,
                   wr.addr != in_addr, "state read races its own write-back")
  `LIF_ASSERT_NEXT(a_rd_hold, clk_i, rst_ni, busy.valid[lifnl_pkg::STG_A] && !accept,
                   $stable(rd_q), "state read data changed under a held item")
  `LIF_ASSERT_NEXT(a_cfg_syn, clk_i, rst_ni,
                   cfg_write && (cfg_index_i == lifnl_pkg::REG_SYN_DECAY),
                   syn_decay_q == $past(cfg_data_i[lifnl_pkg::DECAY_BITS-1:0]),
                   "synaptic decay write lost")

endmodule
